// ===== hdl/rcbs_pkg.sv =====
// ----------------------------------------------------------------------------
// rcbs_pkg
// Shared types and codes for the region crop and bilinear scaler.
// ----------------------------------------------------------------------------
package rcbs_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NUM,
        ST_DIV,
        ST_FETCH,
        ST_WGT,
        ST_MAC,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_EMPTY    = 2'd1;
    localparam logic [1:0] STS_OVERSIZE = 2'd2;
    localparam logic [1:0] STS_RANGE    = 2'd3;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_REQ  = 1'b1;

    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_ROI_LEFT     = 3'd2;
    localparam logic [2:0] REG_ROI_TOP      = 3'd3;
    localparam logic [2:0] REG_ROI_RIGHT    = 3'd4;
    localparam logic [2:0] REG_ROI_BOTTOM   = 3'd5;
    localparam logic [2:0] REG_OUT_SIZE     = 3'd6;

    localparam logic [12:0] RST_FRAME_WIDTH  = 13'd640;
    localparam logic [12:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic [13:0] RST_ROI_LEFT     = 14'd0;
    localparam logic [13:0] RST_ROI_TOP      = 14'd0;
    localparam logic [14:0] RST_ROI_RIGHT    = 15'd112;
    localparam logic [14:0] RST_ROI_BOTTOM   = 15'd112;
    localparam logic [8:0]  RST_OUT_SIZE     = 9'd112;

endpackage

// ===== hdl/rcbs_divider.sv =====
// ----------------------------------------------------------------------------
// rcbs_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcbs_divider #(
    parameter int DIVIDEND_W = 27,
    parameter int DIVISOR_W  = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DIVIDEND_W-1:0]    i_dividend,
    input  logic [DIVISOR_W-1:0]     i_divisor,
    output rcbs_pkg::t_div_status    o_stat,
    output logic [DIVIDEND_W-1:0]    o_quotient
);

    localparam int CW = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_div;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DIVISOR_W:0]    w_shift;
    logic                  w_ge;
    logic [DIVISOR_W:0]    w_rem_next;

    always_comb begin
        w_shift    = {r_rem, r_quo[DIVIDEND_W-1]};
        w_ge       = (w_shift >= {1'b0, r_div});
        w_rem_next = w_ge ? (w_shift - {1'b0, r_div}) : w_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_rem_next[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

// ===== hdl/roi_crop_bilinear_scaler.sv =====
// ----------------------------------------------------------------------------
// roi_crop_bilinear_scaler
// Crops a region from an RGB888 frame and scales it bilinearly to a square.
// ----------------------------------------------------------------------------
// A load (tuser 0) writes the pixel into the region store when it lies
// inside the clamped region. A request (tuser 1) is worked by a small
// sequencer around one shared multiplier and one bit-serial divider: per
// axis one multiply and one divide, then reads of the four neighbours from
// the single-port store, 4 weight products, 12 multiply-accumulate steps
// and the output. A request that ends in an error status goes straight to
// the output. The input is not ready while a request is in progress. The
// store has no reset and no clearing pass; entries never loaded read as
// anything.
module roi_crop_bilinear_scaler #(
    parameter int MAX_REGION_SIDE = 256,
    parameter int FRAC_BITS       = 8,
    parameter int MAX_FRAME_SIDE  = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // pos_x, pos_y, red_in, green_in, blue_in
    input  logic [0:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
    output logic [1:0]  m_axis_tuser,   // status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);

    localparam int LW     = $clog2(MAX_REGION_SIDE);
    localparam int SW     = LW + 1;
    localparam int DEPTH  = MAX_REGION_SIDE * MAX_REGION_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WF     = FRAC_BITS + 1;
    localparam int WW     = 2 * FRAC_BITS + 1;
    localparam int AW     = (WF > 10) ? WF : 10;
    localparam int BW     = (WW > SW) ? WW : SW;
    localparam int NUMW   = 10 + SW;
    localparam int NW     = NUMW + FRAC_BITS;
    localparam int ACW    = 2 * FRAC_BITS + 10;
    localparam logic [WF-1:0]  ONE_FX   = WF'(1) << FRAC_BITS;
    localparam logic [ACW-1:0] HALF_LSB = ACW'(1) << (2 * FRAC_BITS - 1);
    localparam logic [3:0] CNT_FETCH_END = 4'd4;
    localparam logic [3:0] CNT_WGT_END   = 4'd3;
    localparam logic [3:0] CNT_MAC_END   = 4'd11;

    // configuration registers
    logic [12:0]        r_frame_width;
    logic [12:0]        r_frame_height;
    logic signed [13:0] r_roi_left;
    logic signed [13:0] r_roi_top;
    logic signed [14:0] r_roi_right;
    logic signed [14:0] r_roi_bottom;
    logic [8:0]         r_out_size;

    rcbs_pkg::t_state r_state, n_state;
    logic [3:0]      r_cnt;
    logic            r_axis;
    logic            r_neg;
    logic [8:0]      r_dx, r_dy;
    logic [1:0]      r_sts;
    logic [LW-1:0]   r_xa, r_xb, r_ya, r_yb;
    logic [WF-1:0]   r_u, r_v;
    logic [23:0]     r_pix [4];
    logic [WW-1:0]   r_w [4];
    logic [ACW-1:0]  r_acc [3];
    logic [23:0]     r_rdata;
    logic [23:0]     r_mem [DEPTH];
    logic            r_out_valid;
    logic [23:0]     r_out_data;
    logic [1:0]      r_out_sts;

    // input unpacking
    logic        w_func;
    logic [11:0] w_px, w_py;
    logic [23:0] w_rgb;
    logic        w_in_acc;

    // clamped region
    logic [13:0]        w_fw, w_fh;
    logic signed [15:0] w_l, w_t, w_r, w_b, w_w, w_h;
    logic [1:0]         w_area_sts;
    logic [1:0]         w_req_sts;
    logic signed [15:0] w_rx, w_ry;
    logic               w_inside;

    // sequencer controls
    logic [AW-1:0]      w_mul_a;
    logic [BW-1:0]      w_mul_b;
    logic [AW+BW-1:0]   w_prod;
    logic               w_div_start;
    logic [ADDR_W-1:0]  w_mem_addr;
    logic               w_mem_we;
    logic               w_out_go;
    logic [8:0]         w_d;
    logic [SW-1:0]      w_side;
    logic [WF-1:0]      w_wx, w_wy;
    logic [23:0]        w_pixsel;
    logic [7:0]         w_byte;
    logic [LW-1:0]      w_fx, w_fy;

    logic signed [NUMW:0] w_num;
    rcbs_pkg::t_div_status w_div_stat;
    logic [NW-1:0]        w_quo;
    logic [SW-1:0]        w_i0, w_i1;
    logic [WF-1:0]        w_fr;
    logic [ACW-1:0]       w_rnd [3];
    logic [7:0]           w_chan [3];

    assign w_func   = s_axis_tuser[0];
    assign w_px     = s_axis_tdata[11:0];
    assign w_py     = s_axis_tdata[23:12];
    assign w_rgb    = {s_axis_tdata[31:24], s_axis_tdata[39:32], s_axis_tdata[47:40]};
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= rcbs_pkg::RST_FRAME_WIDTH;
            r_frame_height <= rcbs_pkg::RST_FRAME_HEIGHT;
            r_roi_left     <= rcbs_pkg::RST_ROI_LEFT;
            r_roi_top      <= rcbs_pkg::RST_ROI_TOP;
            r_roi_right    <= rcbs_pkg::RST_ROI_RIGHT;
            r_roi_bottom   <= rcbs_pkg::RST_ROI_BOTTOM;
            r_out_size     <= rcbs_pkg::RST_OUT_SIZE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rcbs_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[12:0];
                rcbs_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[12:0];
                rcbs_pkg::REG_ROI_LEFT:     r_roi_left     <= i_cfg_data[13:0];
                rcbs_pkg::REG_ROI_TOP:      r_roi_top      <= i_cfg_data[13:0];
                rcbs_pkg::REG_ROI_RIGHT:    r_roi_right    <= i_cfg_data[14:0];
                rcbs_pkg::REG_ROI_BOTTOM:   r_roi_bottom   <= i_cfg_data[14:0];
                rcbs_pkg::REG_OUT_SIZE:     r_out_size     <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // region clamp
    always_comb begin
        w_fw = ({1'b0, r_frame_width} > 14'(MAX_FRAME_SIDE)) ?
               14'(MAX_FRAME_SIDE) : {1'b0, r_frame_width};
        w_fh = ({1'b0, r_frame_height} > 14'(MAX_FRAME_SIDE)) ?
               14'(MAX_FRAME_SIDE) : {1'b0, r_frame_height};
        w_l  = r_roi_left[13] ? 16'sd0 : 16'(r_roi_left);
        w_t  = r_roi_top[13] ? 16'sd0 : 16'(r_roi_top);
        w_r  = (16'(r_roi_right) > $signed({2'b0, w_fw})) ?
               $signed({2'b0, w_fw}) : 16'(r_roi_right);
        w_b  = (16'(r_roi_bottom) > $signed({2'b0, w_fh})) ?
               $signed({2'b0, w_fh}) : 16'(r_roi_bottom);
        w_w  = w_r - w_l;
        w_h  = w_b - w_t;
        if (w_w <= 16'sd0 || w_h <= 16'sd0) begin
            w_area_sts = rcbs_pkg::STS_EMPTY;
        end else if (w_w > $signed(16'(MAX_REGION_SIDE)) ||
                     w_h > $signed(16'(MAX_REGION_SIDE))) begin
            w_area_sts = rcbs_pkg::STS_OVERSIZE;
        end else begin
            w_area_sts = rcbs_pkg::STS_OK;
        end
        if (w_area_sts != rcbs_pkg::STS_OK) begin
            w_req_sts = w_area_sts;
        end else if (w_px >= {3'b0, r_out_size} || w_py >= {3'b0, r_out_size}) begin
            w_req_sts = rcbs_pkg::STS_RANGE;
        end else begin
            w_req_sts = rcbs_pkg::STS_OK;
        end
        w_rx     = $signed({4'b0, w_px}) - w_l;
        w_ry     = $signed({4'b0, w_py}) - w_t;
        w_inside = (w_area_sts == rcbs_pkg::STS_OK) &&
                   $signed({4'b0, w_px}) >= w_l && $signed({4'b0, w_px}) < w_r &&
                   $signed({4'b0, w_py}) >= w_t && $signed({4'b0, w_py}) < w_b;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rcbs_pkg::ST_IDLE: begin
                if (w_in_acc && w_func == rcbs_pkg::FUNC_REQ) begin
                    n_state = (w_req_sts == rcbs_pkg::STS_OK) ?
                              rcbs_pkg::ST_NUM : rcbs_pkg::ST_OUT;
                end
            end
            rcbs_pkg::ST_NUM: n_state = rcbs_pkg::ST_DIV;
            rcbs_pkg::ST_DIV: begin
                if (w_div_stat.done) begin
                    n_state = r_axis ? rcbs_pkg::ST_FETCH : rcbs_pkg::ST_NUM;
                end
            end
            rcbs_pkg::ST_FETCH: begin
                if (r_cnt == CNT_FETCH_END) n_state = rcbs_pkg::ST_WGT;
            end
            rcbs_pkg::ST_WGT: begin
                if (r_cnt == CNT_WGT_END) n_state = rcbs_pkg::ST_MAC;
            end
            rcbs_pkg::ST_MAC: begin
                if (r_cnt == CNT_MAC_END) n_state = rcbs_pkg::ST_OUT;
            end
            rcbs_pkg::ST_OUT: begin
                if (w_out_go) n_state = rcbs_pkg::ST_IDLE;
            end
            default: n_state = rcbs_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs and shared multiplier operands
    always_comb begin
        s_axis_tready = (r_state == rcbs_pkg::ST_IDLE);
        w_out_go      = (r_state == rcbs_pkg::ST_OUT) && (!r_out_valid || m_axis_tready);
        w_div_start   = (r_state == rcbs_pkg::ST_NUM);
        w_d           = r_axis ? r_dy : r_dx;
        w_side        = r_axis ? w_h[SW-1:0] : w_w[SW-1:0];
        w_wx          = r_cnt[0] ? r_u : (ONE_FX - r_u);
        w_wy          = r_cnt[1] ? r_v : (ONE_FX - r_v);
        w_pixsel      = r_pix[r_cnt[1:0]];
        unique case (r_cnt[3:2])
            2'd0:    w_byte = w_pixsel[23:16];
            2'd1:    w_byte = w_pixsel[15:8];
            default: w_byte = w_pixsel[7:0];
        endcase
        w_fx = r_cnt[0] ? r_xb : r_xa;
        w_fy = r_cnt[1] ? r_yb : r_ya;
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            rcbs_pkg::ST_NUM: begin
                w_mul_a = AW'({w_d, 1'b1});
                w_mul_b = BW'(w_side);
            end
            rcbs_pkg::ST_WGT: begin
                w_mul_a = AW'(w_wx);
                w_mul_b = BW'(w_wy);
            end
            rcbs_pkg::ST_MAC: begin
                w_mul_a = AW'(w_byte);
                w_mul_b = BW'(r_w[r_cnt[1:0]]);
            end
            default: ;
        endcase
        w_mem_we = w_in_acc && (w_func == rcbs_pkg::FUNC_LOAD) && w_inside;
        if (r_state == rcbs_pkg::ST_FETCH) begin
            w_mem_addr = ADDR_W'(int'(w_fy) * MAX_REGION_SIDE + int'(w_fx));
        end else begin
            w_mem_addr = ADDR_W'(int'(w_ry[LW-1:0]) * MAX_REGION_SIDE +
                                 int'(w_rx[LW-1:0]));
        end
    end

    assign w_prod = w_mul_a * w_mul_b;
    assign w_num  = $signed({1'b0, w_prod[NUMW-1:0]}) - $signed((NUMW+1)'(r_out_size));

    rcbs_divider #(
        .DIVIDEND_W (NW),
        .DIVISOR_W  (10)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({w_num[NUMW-1:0], {FRAC_BITS{1'b0}}}),
        .i_divisor  ({r_out_size, 1'b0}),
        .o_stat     (w_div_stat),
        .o_quotient (w_quo)
    );

    // neighbour indices and fraction with edge clamps
    always_comb begin
        if (r_neg) begin
            w_i0 = '0;
            w_i1 = '0;
            w_fr = '0;
        end else begin
            w_i0 = w_quo[FRAC_BITS +: SW];
            w_fr = {1'b0, w_quo[FRAC_BITS-1:0]};
            w_i1 = w_i0 + 1'b1;
            if (w_i1 >= w_side) begin
                w_i1 = w_side - 1'b1;
                w_fr = ONE_FX;
            end
            if (w_i0 > w_side - 1'b1) w_i0 = w_side - 1'b1;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_rnd[c]  = (r_acc[c] + HALF_LSB) >> (2 * FRAC_BITS);
            w_chan[c] = (w_rnd[c] > ACW'(255)) ? 8'd255 : w_rnd[c][7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rcbs_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == rcbs_pkg::ST_IDLE) begin
                r_axis <= 1'b0;
            end else if (r_state == rcbs_pkg::ST_DIV && w_div_stat.done) begin
                r_axis <= 1'b1;
            end
            if (w_out_go) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_dx  <= w_px[8:0];
            r_dy  <= w_py[8:0];
            r_sts <= w_req_sts;
        end
        if (r_state == rcbs_pkg::ST_NUM) r_neg <= w_num[NUMW];
        if (r_state == rcbs_pkg::ST_DIV && w_div_stat.done) begin
            if (r_axis) begin
                r_ya <= w_i0[LW-1:0];
                r_yb <= w_i1[LW-1:0];
                r_v  <= w_fr;
            end else begin
                r_xa <= w_i0[LW-1:0];
                r_xb <= w_i1[LW-1:0];
                r_u  <= w_fr;
            end
        end
        if (r_state == rcbs_pkg::ST_FETCH) begin
            if (r_cnt != '0) r_pix[2'(r_cnt - 1'b1)] <= r_rdata;
            for (int c = 0; c < 3; c++) r_acc[c] <= '0;
        end
        if (r_state == rcbs_pkg::ST_WGT) r_w[r_cnt[1:0]] <= w_prod[WW-1:0];
        if (r_state == rcbs_pkg::ST_MAC) begin
            unique case (r_cnt[3:2])
                2'd0:    r_acc[0] <= r_acc[0] + ACW'(w_prod);
                2'd1:    r_acc[1] <= r_acc[1] + ACW'(w_prod);
                default: r_acc[2] <= r_acc[2] + ACW'(w_prod);
            endcase
        end
        if (w_out_go) begin
            r_out_sts  <= r_sts;
            r_out_data <= (r_sts == rcbs_pkg::STS_OK) ?
                          {w_chan[2], w_chan[1], w_chan[0]} : 24'd0;
        end
    end

    // region store
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[w_mem_addr] <= w_rgb;
        r_rdata <= r_mem[w_mem_addr];
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_sts;

`ifndef SYNTHESIS
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_func == rcbs_pkg::FUNC_LOAD) |=> r_state == rcbs_pkg::ST_IDLE)
        else $error("load transaction started a request sequence");
    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> r_state == rcbs_pkg::ST_DIV)
        else $error("divider finished outside the divide phase");
    a_div_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rcbs_pkg::ST_DIV |-> (w_div_stat.busy || w_div_stat.done))
        else $error("waiting on an idle divider");
    a_store_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> r_state == rcbs_pkg::ST_IDLE)
        else $error("store write during a request");
    a_out_after_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_go |=> (m_axis_tvalid && r_state == rcbs_pkg::ST_IDLE))
        else $error("result transaction not presented");
`endif

endmodule
